// ----- rtl/core/kmc_pkg.sv -----
// kmc_pkg: types, constants and command encodings shared by the
// keyboard/mouse controller modules. no dependencies.
`default_nettype none
package kmc_pkg;

   localparam int QueueDepthDefault = 16;

   localparam logic [2:0] CMD_PORT_WRITE = 3'd0;
   localparam logic [2:0] CMD_PORT_READ  = 3'd1;
   localparam logic [2:0] CMD_KEY_PUSH   = 3'd2;
   localparam logic [2:0] CMD_MOUSE      = 3'd3;
   localparam logic [2:0] CMD_TICK       = 3'd4;

   localparam logic [7:0] PORT_DATA   = 8'h60;
   localparam logic [7:0] PORT_B      = 8'h61;
   localparam logic [7:0] PORT_STATUS = 8'h64;

   localparam logic [7:0] KBC_ECHO_ZERO = 8'h05;
   localparam logic [7:0] KBC_LOAD_KEYS = 8'h11;
   localparam logic [7:0] KBC_LOAD_REL  = 8'h12;

   localparam logic [7:0] REL_HEADER = 8'hfe;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BTN,
      ST_REL_HDR,
      ST_REL_X,
      ST_REL_Y,
      ST_KEY,
      ST_RD_WAIT,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // capture request
      logic       exec;       // execute the captured command
      logic       btn_step;   // handle one button
      logic [1:0] btn_idx;
      logic       rel_push;   // push one relative byte
      logic [1:0] rel_sel;    // 0 header, 1 x, 2 y
      logic       key_step;   // one key-mode motion step
      logic       rd_finish;  // finish a port 0x60 read
      logic       respond;    // drive result strobe
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] cmd;
      logic       is_data_read;
      logic       relative;
      logic       guard2;     // count > depth-2
      logic       guard4;     // count > depth-4
      logic       accum_zero;
      logic       key_pending;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/core/kmc_ram.sv -----
// kmc_ram: generic single-port write, registered read ram.
// no dependencies.
`default_nettype none
module kmc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/kmc_ctrl.sv -----
// kmc_ctrl: sequencing state machine of the controller.
// depends on kmc_pkg.
`default_nettype none
module kmc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire kmc_pkg::stat_type  stat,
   output kmc_pkg::ctrl_type       ctrl
);
   import kmc_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] btn_ff, btn_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         btn_ff   <= '0;
      end else begin
         state_ff <= state_in;
         btn_ff   <= btn_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      btn_in   = btn_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            btn_in = '0;
            if (stat.cmd == CMD_MOUSE) state_in = ST_BTN;
            else if (stat.is_data_read) state_in = ST_RD_WAIT;
            else state_in = ST_DONE;
         end
         ST_BTN: begin
            if (stat.guard2) state_in = ST_DONE;
            else if (btn_ff == 2'd2) begin
               state_in = stat.relative ? ST_REL_HDR : ST_KEY;
            end else btn_in = btn_ff + 2'd1;
         end
         ST_REL_HDR: begin
            if (stat.guard4 || stat.accum_zero) state_in = ST_DONE;
            else state_in = ST_REL_X;
         end
         ST_REL_X: state_in = ST_REL_Y;
         ST_REL_Y: state_in = ST_DONE;
         ST_KEY: begin
            if (!stat.key_pending || stat.guard2) state_in = ST_DONE;
         end
         ST_RD_WAIT: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      busy = (state_ff != ST_IDLE);
      ctrl.load    = (state_ff == ST_IDLE) && start;
      ctrl.btn_idx = btn_ff;
      case (state_ff)
         ST_EXEC: ctrl.exec = 1'b1;
         ST_BTN: ctrl.btn_step = !stat.guard2;
         ST_REL_HDR: begin
            ctrl.rel_sel  = 2'd0;
            ctrl.rel_push = !(stat.guard4 || stat.accum_zero);
         end
         ST_REL_X: begin
            ctrl.rel_sel  = 2'd1;
            ctrl.rel_push = 1'b1;
         end
         ST_REL_Y: begin
            ctrl.rel_sel  = 2'd2;
            ctrl.rel_push = 1'b1;
         end
         ST_KEY: ctrl.key_step = stat.key_pending && !stat.guard2;
         ST_RD_WAIT: ctrl.rd_finish = 1'b1;
         ST_DONE: ctrl.respond = 1'b1;
         default: ctrl.respond = 1'b0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      ctrl.respond |=> state_ff == ST_IDLE)
      else $error("respond not followed by idle");
   assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> state_ff == ST_EXEC)
      else $error("accepted request did not execute");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.exec, ctrl.btn_step, ctrl.rel_push, ctrl.key_step,
                ctrl.rd_finish, ctrl.respond}))
      else $error("conflicting datapath commands");
endmodule
`default_nettype wire

// ----- rtl/core/kmc_datapath.sv -----
// kmc_datapath: ring, latch, status, parameter block, scan table and
// mouse accumulators. depends on kmc_pkg and kmc_ram.
`default_nettype none
module kmc_datapath #(
   parameter int QueueDepth = kmc_pkg::QueueDepthDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [2:0]          req_cmd,
   input  wire logic [7:0]          req_port_addr,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic signed [10:0]  req_move_x,
   input  wire logic signed [10:0]  req_move_y,
   input  wire logic [2:0]          req_buttons,
   input  wire kmc_pkg::ctrl_type   ctrl,
   output kmc_pkg::stat_type        stat,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_irq_pulse,
   output logic                     rsp_mouse_cut_short,
   output logic                     rsp_speaker_gate,
   output logic                     rsp_speaker_enable
);
   import kmc_pkg::*;

   localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CW = AW + 1;

   // request capture
   logic [2:0]         cmd_ff;
   logic [7:0]         port_ff, data_ff;
   logic signed [10:0] mx_ff, my_ff;
   logic [2:0]         btn_req_ff;

   logic [AW-1:0] head_ff, tail_ff;
   logic [7:0] latch_ff, status_ff, lastcmd_ff, portb_ff, rd_ff;
   logic       irqp_ff, rel_ff, irq_out_ff, cut_ff;
   logic [3:0] pidx_ff, pexp_ff;
   logic [7:0] pbuf_ff [9];
   logic [7:0] scan_ff [7];
   logic signed [15:0] ax_ff, ay_ff;
   logic [2:0] bstate_ff;
   logic       valid_ff;

   // ring ram
   logic          wr_en;
   logic [7:0]    wr_data;
   logic [7:0]    ram_q;

   kmc_ram #(.Width(8), .Depth(QueueDepth)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_data),
      .rd_addr (head_ff),
      .rd_data (ram_q)
   );

   // ring occupancy
   logic [CW-1:0] count;
   always_comb begin
      if (tail_ff >= head_ff) count = {1'b0, tail_ff - head_ff};
      else count = CW'(QueueDepth) - {1'b0, head_ff - tail_ff};
   end

   function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
      if ({1'b0, p} == CW'(QueueDepth - 1)) inc = '0;
      else inc = p + AW'(1);
   endfunction

   // relative bytes
   logic signed [15:0] neg_y;
   logic [7:0] cx, cy;
   always_comb begin
      neg_y = (ay_ff == -16'sd32768) ? 16'sd32767 : -ay_ff;
      if (ax_ff < -16'sd127) cx = 8'h81;
      else if (ax_ff > 16'sd127) cx = 8'h7f;
      else cx = ax_ff[7:0];
      if (ay_ff == -16'sd32768) cy = 8'h7f;
      else if (neg_y < -16'sd127) cy = 8'h81;
      else if (neg_y > 16'sd127) cy = 8'h7f;
      else cy = neg_y[7:0];
   end

   // key motion selection
   logic [2:0] key_code_idx;
   logic       kx_neg, kx_pos, ky_neg, ky_pos;
   assign kx_neg = ax_ff < -16'sd4;
   assign kx_pos = ax_ff > 16'sd4;
   assign ky_neg = ay_ff < -16'sd4;
   assign ky_pos = ay_ff > 16'sd4;
   always_comb begin
      if (kx_neg) key_code_idx = 3'd3;
      else if (kx_pos) key_code_idx = 3'd4;
      else if (ky_neg) key_code_idx = 3'd5;
      else key_code_idx = 3'd6;
   end

   // button step
   logic [1:0] bidx;
   logic       bnew, bold;
   logic [7:0] bcode;
   always_comb begin
      bidx = ctrl.btn_idx;
      bnew = btn_req_ff[bidx];
      bold = bstate_ff[bidx];
      case (bidx)
         2'd0: bcode = scan_ff[0];
         2'd1: bcode = scan_ff[2];
         default: bcode = scan_ff[1];
      endcase
   end

   logic data_wr, param_phase, ring_nonempty;
   assign data_wr      = (cmd_ff == CMD_PORT_WRITE) && (port_ff == PORT_DATA);
   assign param_phase  = pidx_ff != pexp_ff;
   assign ring_nonempty = head_ff != tail_ff;

   // ring writes
   always_comb begin
      wr_en   = 1'b0;
      wr_data = 8'h00;
      if (ctrl.exec) begin
         if (cmd_ff == CMD_KEY_PUSH) begin
            wr_en = 1'b1;
            wr_data = data_ff;
         end else if (data_wr && !param_phase && data_ff == KBC_ECHO_ZERO) begin
            wr_en = 1'b1;
         end
      end else if (ctrl.btn_step && (bnew != bold)) begin
         wr_en = 1'b1;
         wr_data = bnew ? bcode : (bcode | 8'h80);
      end else if (ctrl.rel_push) begin
         wr_en = 1'b1;
         case (ctrl.rel_sel)
            2'd0: wr_data = REL_HEADER;
            2'd1: wr_data = cx;
            default: wr_data = cy;
         endcase
      end else if (ctrl.key_step) begin
         wr_en = 1'b1;
         wr_data = scan_ff[key_code_idx];
      end
   end

   // saturating accumulate
   logic signed [16:0] sx, sy;
   assign sx = 17'(ax_ff) + 17'(mx_ff);
   assign sy = 17'(ay_ff) + 17'(my_ff);

   function automatic logic signed [15:0] sat(input logic signed [16:0] v);
      if (v > 17'sd32767) sat = 16'sd32767;
      else if (v < -17'sd32768) sat = -16'sd32768;
      else sat = v[15:0];
   endfunction

   logic [3:0] pidx_next;
   assign pidx_next = pidx_ff + 4'd1;

   // phase tracking for the cut-short flag
   logic mouse_phase, phase_btn, phase_key, phase_rel;
   logic [1:0] phase_ff;
   always_ff @(posedge clock) begin
      if (reset) phase_ff <= 2'd0;
      else if (ctrl.exec) phase_ff <= 2'd1;
      else if (ctrl.btn_step && ctrl.btn_idx == 2'd2) phase_ff <= rel_ff ? 2'd3 : 2'd2;
      else if (ctrl.respond || ctrl.rel_push) phase_ff <= 2'd0;
   end
   assign mouse_phase = (cmd_ff == CMD_MOUSE) && (phase_ff != 2'd0);
   assign phase_btn   = phase_ff == 2'd1;
   assign phase_key   = phase_ff == 2'd2;
   assign phase_rel   = phase_ff == 2'd3;

   // report stopped by the queue guard
   logic guard_stop;
   assign guard_stop = mouse_phase && (
      (phase_btn && stat.guard2) ||
      (phase_key && stat.key_pending && stat.guard2) ||
      (phase_rel && stat.guard4));

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff     <= req_cmd;
         port_ff    <= req_port_addr;
         data_ff    <= req_data_byte;
         mx_ff      <= req_move_x;
         my_ff      <= req_move_y;
         btn_req_ff <= req_buttons;
      end
      if (ctrl.exec && data_wr && param_phase && pidx_ff < 4'd9) begin
         pbuf_ff[pidx_ff] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         latch_ff   <= 8'h00;
         status_ff  <= 8'h18;
         irqp_ff    <= 1'b0;
         lastcmd_ff <= 8'h00;
         pidx_ff    <= 4'd0;
         pexp_ff    <= 4'd0;
         scan_ff    <= '{8'h1c, 8'h53, 8'h01, 8'h4b, 8'h4d, 8'h48, 8'h50};
         rel_ff     <= 1'b0;
         ax_ff      <= '0;
         ay_ff      <= '0;
         bstate_ff  <= '0;
         portb_ff   <= 8'h00;
         rd_ff      <= 8'h00;
         irq_out_ff <= 1'b0;
         cut_ff     <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= ctrl.respond;
         if (wr_en) tail_ff <= inc(tail_ff);
         if (ctrl.load) begin
            rd_ff      <= 8'h00;
            irq_out_ff <= 1'b0;
            cut_ff     <= 1'b0;
         end
         if (ctrl.exec) begin
            case (cmd_ff)
               CMD_PORT_WRITE: begin
                  if (data_wr) begin
                     if (param_phase) begin
                        pidx_ff <= pidx_next;
                        if (pidx_next == pexp_ff) begin
                           if (lastcmd_ff == KBC_LOAD_KEYS) begin
                              rel_ff <= 1'b0;
                              for (int i = 0; i < 7; i++) scan_ff[i] <= pbuf_ff[i];
                           end else if (lastcmd_ff == KBC_LOAD_REL) begin
                              rel_ff <= 1'b1;
                              for (int i = 0; i < 3; i++) scan_ff[i] <= pbuf_ff[i];
                           end
                        end
                     end else begin
                        lastcmd_ff <= data_ff;
                        if (data_ff == KBC_LOAD_KEYS) begin
                           pidx_ff <= 4'd0;
                           pexp_ff <= 4'd9;
                        end else if (data_ff == KBC_LOAD_REL) begin
                           pidx_ff <= 4'd0;
                           pexp_ff <= 4'd4;
                        end
                     end
                  end else if (port_ff == PORT_B) begin
                     portb_ff <= data_ff;
                  end
               end
               CMD_PORT_READ: begin
                  case (port_ff)
                     PORT_DATA: rd_ff <= latch_ff;
                     PORT_B: rd_ff <= portb_ff;
                     PORT_STATUS: begin
                        rd_ff     <= status_ff;
                        status_ff <= status_ff & 8'h9f;
                     end
                     default: rd_ff <= 8'hff;
                  endcase
               end
               CMD_MOUSE: begin
                  ax_ff <= sat(sx);
                  ay_ff <= sat(sy);
               end
               CMD_TICK: begin
                  // the latch refill waits for the ring read and is done in the response cycle
                  if (irqp_ff) begin
                     irqp_ff    <= 1'b0;
                     irq_out_ff <= 1'b1;
                  end
               end
               default: rd_ff <= 8'h00;
            endcase
         end
         if (ctrl.rd_finish) begin
            if (!ring_nonempty) begin
               status_ff[0] <= 1'b0;
               irqp_ff      <= 1'b0;
            end else begin
               latch_ff  <= ram_q;
               head_ff   <= inc(head_ff);
               status_ff <= (status_ff | 8'h01) & 8'hfd;
               irqp_ff   <= 1'b1;
            end
         end
         // tick refill in the response cycle, ram data is settled by then
         if (ctrl.respond && cmd_ff == CMD_TICK && !status_ff[0] && ring_nonempty) begin
            latch_ff  <= ram_q;
            head_ff   <= inc(head_ff);
            status_ff <= (status_ff | 8'h01) & 8'hfd;
            irqp_ff   <= 1'b1;
         end
         if (ctrl.btn_step) bstate_ff[bidx] <= bnew;
         if (ctrl.rel_push && ctrl.rel_sel == 2'd2) begin
            ax_ff <= '0;
            ay_ff <= '0;
         end
         if (ctrl.key_step) begin
            if (kx_neg) ax_ff <= ax_ff + 16'sd4;
            else if (kx_pos) ax_ff <= ax_ff - 16'sd4;
            else if (ky_neg) ay_ff <= ay_ff + 16'sd4;
            else ay_ff <= ay_ff - 16'sd4;
         end
         if (guard_stop) cut_ff <= 1'b1;
      end
   end

   always_comb begin
      stat.cmd          = cmd_ff;
      stat.is_data_read = (cmd_ff == CMD_PORT_READ) && (port_ff == PORT_DATA);
      stat.relative     = rel_ff;
      stat.guard2       = count > CW'(QueueDepth - 2);
      stat.guard4       = count > CW'(QueueDepth - 4);
      stat.accum_zero   = (ax_ff == 16'sd0) && (ay_ff == 16'sd0);
      stat.key_pending  = kx_neg || kx_pos || ky_neg || ky_pos;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_read_data       = rd_ff;
   assign rsp_irq_pulse       = irq_out_ff;
   assign rsp_mouse_cut_short = cut_ff;
   assign rsp_speaker_gate    = portb_ff[0];
   assign rsp_speaker_enable  = portb_ff[1];

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(ctrl.respond))
      else $error("result without respond command");
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.key_step || ctrl.btn_step) |-> !stat.guard2)
      else $error("mouse push past queue guard");
   assert property (@(posedge clock) disable iff (reset)
      rsp_irq_pulse && rsp_valid |-> cmd_ff == CMD_TICK)
      else $error("irq pulse outside poll tick");
endmodule
`default_nettype wire

// ----- rtl/core/keyboard_mouse_controller_unit.sv -----
// keyboard_mouse_controller_unit: top level of the keyboard/mouse controller.
// depends on kmc_pkg, kmc_ctrl, kmc_datapath and kmc_ram.
`default_nettype none
// a request is taken when start is high and busy is low; every transaction
// gives exactly one result, shown for a single cycle with rsp_valid and
// never held, so the receiver must take it when it appears. writes, reads
// of ports other than 0x60, key pushes and poll ticks go from the execute
// state straight to the result; a read of port 0x60 adds a wait state for
// the ring ram read. a mouse report walks the buttons, then takes one key
// step per motion code in key mode, or in relative mode a header step and,
// with a packet, x and y steps, and it ends early when the queue guard stops:
// the sequencer walks the three buttons one per cycle and then pushes one
// ring byte per cycle through the single ram write port. the ring is a
// QUEUE_DEPTH byte ram whose contents are undefined until written.
module keyboard_mouse_controller_unit #(
   parameter int QUEUE_DEPTH = kmc_pkg::QueueDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_cmd,
   input  wire logic [7:0]         req_port_addr,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic signed [10:0] req_move_x,
   input  wire logic signed [10:0] req_move_y,
   input  wire logic [2:0]         req_buttons,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_read_data,
   output logic                    rsp_irq_pulse,
   output logic                    rsp_mouse_cut_short,
   output logic                    rsp_speaker_gate,
   output logic                    rsp_speaker_enable
);
   import kmc_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   // sequencer
   kmc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // ring, registers and mouse arithmetic
   kmc_datapath #(.QueueDepth(QUEUE_DEPTH)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_port_addr       (req_port_addr),
      .req_data_byte       (req_data_byte),
      .req_move_x          (req_move_x),
      .req_move_y          (req_move_y),
      .req_buttons         (req_buttons),
      .ctrl                (ctrl),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_read_data       (rsp_read_data),
      .rsp_irq_pulse       (rsp_irq_pulse),
      .rsp_mouse_cut_short (rsp_mouse_cut_short),
      .rsp_speaker_gate    (rsp_speaker_gate),
      .rsp_speaker_enable  (rsp_speaker_enable)
   );

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but not busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");
endmodule
`default_nettype wire
